// ===== rtl/assert_macros.svh =====
// assertion macros for the range type resolver
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== rtl/mtrr_pkg.sv =====
// ----------------------------------------------------------------------------
// mtrr_pkg
// shared constants and types of the range type resolver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package mtrr_pkg;
	localparam int TableEntries = 128;
	localparam int AddressBits = 52;
	localparam int IdxW = $clog2(TableEntries);
	localparam int CntW = $clog2(TableEntries + 1);
	localparam int PageAddrW = 61;

	localparam logic [2:0] TYPE_UC = 3'd0;
	localparam logic [2:0] TYPE_WB = 3'd6;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [0:0] REG_ENTRIES = 1'd0;
	localparam logic [0:0] REG_DEFAULT = 1'd1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_INDEX = 2'd1;
	localparam logic [1:0] ST_BAD_PAGE = 2'd2;

	typedef struct packed {
		logic [AddressBits-1:0] rstart;
		logic [AddressBits-1:0] rend;
		logic [2:0] rtype;
		logic rfixed;
	} entry_t;

	// partial answer carried along the scan
	typedef struct packed {
		logic [2:0] cont;
		logic cont_done;
		logic [2:0] ovl;
		logic ovl_done;
		logic split;
	} acc_t;

	typedef struct packed {
		logic [AddressBits-1:0] ps;
		logic [AddressBits-1:0] pe;
	} page_t;
endpackage

// ===== rtl/mtrr_if.sv =====
// ----------------------------------------------------------------------------
// mtrr interfaces
// valid/ready channels of the range type resolver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface mtrr_in_if;
	logic valid;
	logic ready;
	logic operation;
	logic [6:0] entry_index;
	logic [51:0] range_start;
	logic [51:0] range_end;
	logic [2:0] range_type;
	logic range_fixed;
	logic [39:0] page_frame;
	logic page_2m;
	modport source (output valid, operation, entry_index, range_start, range_end,
		range_type, range_fixed, page_frame, page_2m, input ready);
	modport sink (input valid, operation, entry_index, range_start, range_end,
		range_type, range_fixed, page_frame, page_2m, output ready);
endinterface

interface mtrr_out_if;
	logic valid;
	logic ready;
	logic [2:0] contained_type;
	logic [2:0] overlap_type;
	logic boundary_splits;
	logic [1:0] status;
	modport source (output valid, contained_type, overlap_type, boundary_splits,
		status, input ready);
	modport sink (input valid, contained_type, overlap_type, boundary_splits,
		status, output ready);
endinterface

interface mtrr_cfg_if;
	logic valid;
	logic ready;
	logic [0:0] index;
	logic [7:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/mtrr_cell.sv =====
// ----------------------------------------------------------------------------
// mtrr_cell
// holds one range entry and folds it into the partial answer passing by
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mtrr_cell
	import mtrr_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  entry_t wr_entry,
	input  logic   active,
	input  logic   ovl_skip,
	input  page_t  page,
	input  logic   tok_in,
	input  acc_t   acc_in,
	output logic   tok_out,
	output acc_t   acc_out
);
	entry_t ent_q;
	acc_t acc_q;
	acc_t acc_fold;
	logic tok_q;
	logic hit_c, hit_o, sp;

	// entry storage
	always_ff @(posedge clk) begin
		if (wr_en) ent_q <= wr_entry;
	end

	// compare and fold
	always_comb begin
		hit_c = (page.ps >= ent_q.rstart) && (page.pe <= ent_q.rend);
		hit_o = (page.ps <= ent_q.rend) && (page.pe >= ent_q.rstart);
		sp = ((page.ps <= ent_q.rend) && (page.pe > ent_q.rend)) ||
			((page.ps < ent_q.rstart) && (page.pe >= ent_q.rstart));
		acc_fold = acc_in;
		if (active) begin
			if (!acc_in.cont_done && hit_c) begin
				acc_fold.cont = ent_q.rtype;
				acc_fold.cont_done = ent_q.rfixed || (ent_q.rtype == TYPE_UC);
			end
			if (!ovl_skip && !acc_in.ovl_done && hit_o) begin
				acc_fold.ovl = ent_q.rtype;
				acc_fold.ovl_done = (ent_q.rtype == TYPE_UC);
			end
			if (sp) acc_fold.split = 1'b1;
		end
	end

	// token moves one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tok_q <= 1'b0;
		else tok_q <= tok_in;
	end

	// partial answer travels with the token
	always_ff @(posedge clk) begin
		if (tok_in) acc_q <= acc_fold;
	end

	assign tok_out = tok_q;
	assign acc_out = acc_q;
endmodule

// ===== rtl/memory_range_type_resolver_top.sv =====
// ----------------------------------------------------------------------------
// memory_range_type_resolver_top
// range table with in-order containment, overlap and split scan
// ----------------------------------------------------------------------------
// Usage: items arrive on in_ch, results leave on out_ch, registers are
// written on cfg_ch (index 0 entries_in_use, index 1 default_type).
// A write item stores its entry in the addressed cell; its result is valid
// in the next cycle; writes can follow one a cycle while out_ch is ready.
// A page beyond the address space answers in the same way.
// A query hands a token and its partial answer down the row of 128 cells,
// one cell per cycle; cells past entries_in_use pass it on unchanged. The
// result is registered when the token leaves the last cell and the next item
// can transfer with it, so the time a query takes is set by the row length.
// One item is worked at a time. The result sits in an output register and
// the next item is taken only when that register is empty or transfers in
// the same cycle, so a stalled receiver holds the block and its input.
// Reset clears the registers and control; entries are undefined until
// written. No clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module memory_range_type_resolver_top
	import mtrr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	mtrr_in_if.sink    in_ch,
	mtrr_out_if.source out_ch,
	mtrr_cfg_if.sink   cfg_ch
);
	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t state_q;
	logic [7:0] entries_q;
	logic [2:0] deftype_q;
	logic [CntW-1:0] limit_q;
	logic start_q;
	page_t page_q;
	logic ovl_skip_q;
	acc_t acc_q;
	logic out_valid_q;
	logic [2:0] out_cont_q, out_ovl_q;
	logic out_split_q;
	logic [1:0] out_status_q;

	acc_t chain [TableEntries+1];
	logic [TableEntries:0] tok_chain;
	logic in_fire, out_fire;
	logic page_bad, scan_go, scan_end, out_set;
	logic [PageAddrW-1:0] ps_w, pe_w;
	entry_t wr_entry;

	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready = (state_q == S_IDLE) && (!out_valid_q || out_ch.ready);
	assign in_fire = in_ch.valid && in_ch.ready;
	assign out_fire = out_valid_q && out_ch.ready;

	// page bounds of the incoming query and the entry of a write item
	always_comb begin
		if (in_ch.page_2m) begin
			ps_w = {in_ch.page_frame, 21'd0};
			pe_w = {in_ch.page_frame, {21{1'b1}}};
		end else begin
			ps_w = {9'd0, in_ch.page_frame, 12'd0};
			pe_w = {9'd0, in_ch.page_frame, {12{1'b1}}};
		end
		wr_entry.rstart = in_ch.range_start;
		wr_entry.rend = in_ch.range_end;
		wr_entry.rtype = in_ch.range_type;
		wr_entry.rfixed = in_ch.range_fixed;
	end

	// item decode
	assign page_bad = (pe_w[PageAddrW-1:AddressBits] != '0);
	assign scan_go = in_fire && (in_ch.operation == OP_QUERY) && !page_bad;
	assign scan_end = (state_q == S_SCAN) && tok_chain[TableEntries];
	assign out_set = (in_fire && !scan_go) || scan_end;

	// row of cells; cells below the scan limit fold their entry
	assign chain[0] = acc_q;
	assign tok_chain[0] = start_q;
	genvar g;
	generate
		for (g = 0; g < TableEntries; g++) begin : g_cell
			mtrr_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.wr_en(in_fire && in_ch.operation == OP_WRITE &&
					in_ch.entry_index == IdxW'(g)),
				.wr_entry(wr_entry),
				.active(CntW'(g) < limit_q),
				.ovl_skip(ovl_skip_q),
				.page(page_q),
				.tok_in(tok_chain[g]),
				.acc_in(chain[g]),
				.tok_out(tok_chain[g+1]),
				.acc_out(chain[g+1])
			);
		end
	endgenerate

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= '0;
			deftype_q <= '0;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				REG_ENTRIES: entries_q <= cfg_ch.data;
				REG_DEFAULT: deftype_q <= cfg_ch.data[2:0];
				default: ;
			endcase
		end
	end

	// control and scan sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			start_q <= 1'b0;
		end else begin
			out_valid_q <= out_set || (out_valid_q && !out_fire);
			start_q <= scan_go;
			case (state_q)
				S_IDLE: begin
					if (scan_go) state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (tok_chain[TableEntries]) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			page_q.ps <= ps_w[AddressBits-1:0];
			page_q.pe <= pe_w[AddressBits-1:0];
			ovl_skip_q <= in_ch.page_2m && (in_ch.page_frame == '0);
			limit_q <= (entries_q > 8'(TableEntries)) ? CntW'(TableEntries)
				: CntW'(entries_q);
			acc_q <= '{cont: deftype_q, cont_done: 1'b0, ovl: TYPE_WB,
				ovl_done: 1'b0, split: 1'b0};
			out_cont_q <= '0;
			out_ovl_q <= '0;
			out_split_q <= 1'b0;
			out_status_q <= (in_ch.operation == OP_WRITE) ? ST_OK : ST_BAD_PAGE;
		end else if (scan_end) begin
			out_cont_q <= chain[TableEntries].cont;
			out_ovl_q <= ovl_skip_q ? TYPE_UC : chain[TableEntries].ovl;
			out_split_q <= chain[TableEntries].split;
			out_status_q <= ST_OK;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.contained_type = out_cont_q;
	assign out_ch.overlap_type = out_ovl_q;
	assign out_ch.boundary_splits = out_split_q;
	assign out_ch.status = out_status_q;

	// checks
	`ASSERT_NEVER(a_no_accept_busy, clk, arst_n, in_fire && state_q != S_IDLE)
	`ASSERT_IMPL(a_scan_ends, clk, arst_n, scan_end |=> out_valid_q)
	`ASSERT_NEVER(a_scan_out_empty, clk, arst_n, state_q == S_SCAN && out_valid_q)
endmodule
